/* hw/rtl/rx_ring_buffer_with_overrun_defines.svh */
// Assertion macros for the receive ring buffer
`ifndef RX_RING_BUFFER_WITH_OVERRUN_DEFINES_SVH
`define RX_RING_BUFFER_WITH_OVERRUN_DEFINES_SVH

`ifndef ASSERT_OFF
`define RXRB_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define RXRB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define RXRB_ASSERT_NOW(lbl, ante, cons, msg)
`define RXRB_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

/* hw/rtl/rxrb_pkg.sv */
// Shared types and constants for the receive ring buffer
`default_nettype none
package rxrb_pkg;

  localparam int unsigned BUFFER_DEPTH_DEF = 256;
  localparam int unsigned MAX_READ_RUN     = 64;

  localparam int unsigned OP_W     = 3;
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned CNT_W    = 7;
  localparam int unsigned SKIP_W   = 9;
  localparam int unsigned FOUND_W  = 8;
  localparam int unsigned LEVEL_W  = 9;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned WRAP_W   = 2;

  localparam logic [WRAP_W-1:0] WRAP_LIMIT = 2'd3;

  typedef enum logic [OP_W-1:0] {
    OP_RECV = 3'd0,
    OP_READ = 3'd1,
    OP_PEEK = 3'd2,
    OP_SKIP = 3'd3,
    OP_FIND = 3'd4
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_SHORT     = 2'd1,
    ST_NOT_FOUND = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD_ISSUE,
    S_RD_WAIT,
    S_ADVANCE,
    S_FIND_ISSUE,
    S_FIND_CMP,
    S_EMIT
  } state_t;

endpackage
`default_nettype wire

/* hw/rtl/rxrb_ram.sv */
// Generic single-port-write, registered-read RAM
`default_nettype none
module rxrb_ram #(
  parameter int unsigned WIDTH = rxrb_pkg::BYTE_W,
  parameter int unsigned DEPTH = rxrb_pkg::BUFFER_DEPTH_DEF,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/rxrb_level.sv */
// Fill level and overrun detection from the write index, read index and wrap count
`default_nettype none
module rxrb_level #(
  parameter int unsigned DEPTH = rxrb_pkg::BUFFER_DEPTH_DEF,
  localparam int unsigned IW = $clog2(DEPTH),
  localparam int unsigned LW = $clog2(DEPTH + 1)
) (
  input  wire logic [IW-1:0]               wr_idx,
  input  wire logic [IW-1:0]               rd_idx,
  input  wire logic [rxrb_pkg::WRAP_W-1:0] wrap,
  output logic      [LW-1:0]               level,
  output logic                             overrun
);
  import rxrb_pkg::*;

  localparam logic [LW-1:0] FULL = LW'(DEPTH);

  logic [IW-1:0] diff_wr;
  logic [IW-1:0] diff_rd;

  assign diff_wr = wr_idx - rd_idx;
  assign diff_rd = rd_idx - wr_idx;

  always_comb begin
    overrun = 1'b0;
    level   = '0;
    if (wrap == '0) begin
      level = (wr_idx >= rd_idx) ? LW'(diff_wr) : '0;
    end else if (wrap == WRAP_W'(1) && wr_idx <= rd_idx) begin
      level = FULL - LW'(diff_rd);
    end else begin
      overrun = 1'b1;
      level   = FULL;
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/rx_ring_buffer_with_overrun.sv */
// Receive ring buffer with overrun recovery: read, peek, skip and find over one byte RAM
// Receive: one byte per cycle while in_ready is high (idle), accepted back to back; no result.
// Read of n bytes: accept, then per byte a read issue and a read wait, then index advance.
// Peek: read issue and wait; status-only results: straight to emit; skip: index advance
//   (up to 2 wraps), then emit; find: issue and compare per byte. Results wait on out_ready.
// Reset clears the indexes, wrap count and output valid; RAM contents are kept.
`default_nettype none
`include "rx_ring_buffer_with_overrun_defines.svh"
module rx_ring_buffer_with_overrun #(
  parameter int unsigned BUFFER_DEPTH = rxrb_pkg::BUFFER_DEPTH_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic [rxrb_pkg::OP_W-1:0]      in_operation,
  input  wire logic [rxrb_pkg::BYTE_W-1:0]    in_rx_byte,
  input  wire logic [rxrb_pkg::CNT_W-1:0]     in_read_count,
  input  wire logic [rxrb_pkg::SKIP_W-1:0]    in_skip_length,
  input  wire logic [rxrb_pkg::BYTE_W-1:0]    in_match_a,
  input  wire logic [rxrb_pkg::BYTE_W-1:0]    in_match_b,
  input  wire logic                           in_match_two,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic      [rxrb_pkg::BYTE_W-1:0]    out_data_byte,
  output logic      [rxrb_pkg::FOUND_W-1:0]   out_found_index,
  output logic      [rxrb_pkg::LEVEL_W-1:0]   out_fill_level,
  output logic      [rxrb_pkg::STATUS_W-1:0]  out_status,
  output logic                                out_overrun_seen,
  output logic                                out_last
);
  import rxrb_pkg::*;

  localparam int unsigned IW = $clog2(BUFFER_DEPTH);
  localparam int unsigned LW = $clog2(BUFFER_DEPTH + 1);
  localparam int unsigned OW = (LW > CNT_W) ? LW : CNT_W;
  localparam int unsigned PW = $clog2(BUFFER_DEPTH + (2 ** SKIP_W));

  // control state
  state_t              state_r, state_nxt;
  logic [IW-1:0]       wr_idx_r, wr_idx_nxt;
  logic [IW-1:0]       rd_idx_r, rd_idx_nxt;
  logic [WRAP_W-1:0]   wrap_r, wrap_nxt;
  logic                out_valid_r, out_valid_nxt;

  // per-item working registers
  logic [LW-1:0]       level_r, level_nxt;
  logic                ovr_r, ovr_nxt;
  logic                peek_r, peek_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [CNT_W-1:0]    n_r, n_nxt;
  logic [LW-1:0]       idx_r, idx_nxt;
  logic [PW-1:0]       pos_r, pos_nxt;
  logic                emit_after_r, emit_after_nxt;
  logic [BYTE_W-1:0]   match_a_r, match_a_nxt;
  logic [BYTE_W-1:0]   match_b_r, match_b_nxt;
  logic                match_two_r, match_two_nxt;
  status_t             pend_status_r, pend_status_nxt;
  logic [FOUND_W-1:0]  pend_found_r, pend_found_nxt;

  // output register
  logic [BYTE_W-1:0]   out_data_r, out_data_nxt;
  logic [FOUND_W-1:0]  out_found_r, out_found_nxt;
  logic [LEVEL_W-1:0]  out_level_r, out_level_nxt;
  status_t             out_status_r, out_status_nxt;
  logic                out_ovr_r, out_ovr_nxt;
  logic                out_last_r, out_last_nxt;

  logic                out_free;
  logic                out_load;
  op_t                 in_op;
  logic                op_known;
  logic                in_xfer;

  logic [LW-1:0]       rec_level;
  logic                rec_ovr;
  logic [IW-1:0]       rd_eff;

  logic                ram_we;
  logic                ram_re;
  logic [IW-1:0]       ram_raddr;
  logic [BYTE_W-1:0]   ram_rdata;

  logic [OW-1:0]       rd_off;
  logic [OW:0]         rd_sum;
  logic [OW:0]         rd_sum_wrap;
  logic [CNT_W-1:0]    cnt_inc;
  logic [LW-1:0]       idx_inc;
  logic                hit;

  rxrb_level #(
    .DEPTH (BUFFER_DEPTH)
  ) u_level (
    .wr_idx  (wr_idx_r),
    .rd_idx  (rd_idx_r),
    .wrap    (wrap_r),
    .level   (rec_level),
    .overrun (rec_ovr)
  );

  rxrb_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (BUFFER_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wr_idx_r),
    .wdata (in_rx_byte),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign in_op    = op_t'(in_operation);
  assign op_known = (in_op == OP_READ) || (in_op == OP_PEEK) ||
                    (in_op == OP_SKIP) || (in_op == OP_FIND);
  assign in_ready = (state_r == S_IDLE);
  assign in_xfer  = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;
  assign rd_eff   = rec_ovr ? wr_idx_r : rd_idx_r;

  // read address: read index plus offset, folded into the store
  assign rd_off      = (state_r == S_FIND_ISSUE) ? OW'(idx_r) : OW'(cnt_r);
  assign rd_sum      = (OW + 1)'(rd_idx_r) + (OW + 1)'(rd_off);
  assign rd_sum_wrap = (rd_sum >= (OW + 1)'(BUFFER_DEPTH)) ?
                       rd_sum - (OW + 1)'(BUFFER_DEPTH) : rd_sum;
  assign ram_raddr   = IW'(rd_sum_wrap);
  assign ram_re      = (state_r == S_RD_ISSUE) || (state_r == S_FIND_ISSUE);
  assign ram_we      = in_xfer && (in_op == OP_RECV);

  assign cnt_inc = cnt_r + CNT_W'(1);
  assign idx_inc = idx_r + LW'(1);
  assign hit     = (ram_rdata == match_a_r) || (match_two_r && (ram_rdata == match_b_r));

  always_comb begin
    state_nxt       = state_r;
    wr_idx_nxt      = wr_idx_r;
    rd_idx_nxt      = rd_idx_r;
    wrap_nxt        = wrap_r;
    level_nxt       = level_r;
    ovr_nxt         = ovr_r;
    peek_nxt        = peek_r;
    cnt_nxt         = cnt_r;
    n_nxt           = n_r;
    idx_nxt         = idx_r;
    pos_nxt         = pos_r;
    emit_after_nxt  = emit_after_r;
    match_a_nxt     = match_a_r;
    match_b_nxt     = match_b_r;
    match_two_nxt   = match_two_r;
    pend_status_nxt = pend_status_r;
    pend_found_nxt  = pend_found_r;
    out_load        = 1'b0;
    out_data_nxt    = out_data_r;
    out_found_nxt   = out_found_r;
    out_level_nxt   = out_level_r;
    out_status_nxt  = out_status_r;
    out_ovr_nxt     = out_ovr_r;
    out_last_nxt    = out_last_r;

    case (state_r)
      S_IDLE: begin
        if (in_xfer && op_known) begin
          // overrun recovery ahead of every read, peek, skip and find operation
          level_nxt      = rec_level;
          ovr_nxt        = rec_ovr;
          pend_found_nxt = '0;
          if (rec_ovr) begin
            rd_idx_nxt = wr_idx_r;
            wrap_nxt   = WRAP_W'(1);
          end
        end
        if (in_xfer) begin
          case (in_op)
            OP_RECV: begin
              if (wr_idx_r == IW'(BUFFER_DEPTH - 1)) begin
                wr_idx_nxt = '0;
                if (wrap_r != WRAP_LIMIT) begin
                  wrap_nxt = wrap_r + WRAP_W'(1);
                end
              end else begin
                wr_idx_nxt = wr_idx_r + IW'(1);
              end
            end
            OP_READ: begin
              if (in_read_count == '0) begin
                pend_status_nxt = ST_OK;
                state_nxt       = S_EMIT;
              end else if ((in_read_count > CNT_W'(MAX_READ_RUN)) ||
                           (OW'(rec_level) < OW'(in_read_count))) begin
                pend_status_nxt = ST_SHORT;
                state_nxt       = S_EMIT;
              end else begin
                n_nxt     = in_read_count;
                cnt_nxt   = '0;
                peek_nxt  = 1'b0;
                state_nxt = S_RD_ISSUE;
              end
            end
            OP_PEEK: begin
              if (rec_level != '0) begin
                n_nxt     = CNT_W'(1);
                cnt_nxt   = '0;
                peek_nxt  = 1'b1;
                state_nxt = S_RD_ISSUE;
              end else begin
                pend_status_nxt = ST_SHORT;
                state_nxt       = S_EMIT;
              end
            end
            OP_SKIP: begin
              pos_nxt         = PW'(rd_eff) + PW'(in_skip_length);
              emit_after_nxt  = 1'b1;
              pend_status_nxt = ST_OK;
              state_nxt       = S_ADVANCE;
            end
            OP_FIND: begin
              match_a_nxt   = in_match_a;
              match_b_nxt   = in_match_b;
              match_two_nxt = in_match_two;
              idx_nxt       = '0;
              if (rec_level == '0) begin
                pend_status_nxt = ST_NOT_FOUND;
                state_nxt       = S_EMIT;
              end else begin
                state_nxt = S_FIND_ISSUE;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_RD_ISSUE: begin
        state_nxt = S_RD_WAIT;
      end
      S_RD_WAIT: begin
        if (out_free) begin
          out_load       = 1'b1;
          out_data_nxt   = ram_rdata;
          out_found_nxt  = '0;
          out_level_nxt  = LEVEL_W'(level_r);
          out_status_nxt = ST_OK;
          out_ovr_nxt    = ovr_r;
          out_last_nxt   = (cnt_inc == n_r);
          if (cnt_inc == n_r) begin
            if (peek_r) begin
              state_nxt = S_IDLE;
            end else begin
              pos_nxt        = PW'(rd_idx_r) + PW'(n_r);
              emit_after_nxt = 1'b0;
              state_nxt      = S_ADVANCE;
            end
          end else begin
            cnt_nxt   = cnt_inc;
            state_nxt = S_RD_ISSUE;
          end
        end
      end
      S_ADVANCE: begin
        // drop one store length per cycle, lowering the wrap count
        if (pos_r >= PW'(BUFFER_DEPTH)) begin
          pos_nxt = pos_r - PW'(BUFFER_DEPTH);
          if (wrap_r != '0) begin
            wrap_nxt = wrap_r - WRAP_W'(1);
          end
        end else begin
          rd_idx_nxt = IW'(pos_r);
          state_nxt  = emit_after_r ? S_EMIT : S_IDLE;
        end
      end
      S_FIND_ISSUE: begin
        state_nxt = S_FIND_CMP;
      end
      S_FIND_CMP: begin
        if (hit) begin
          pend_found_nxt  = FOUND_W'(idx_r);
          pend_status_nxt = ST_OK;
          state_nxt       = S_EMIT;
        end else if (idx_inc == level_r) begin
          pend_found_nxt  = '0;
          pend_status_nxt = ST_NOT_FOUND;
          state_nxt       = S_EMIT;
        end else begin
          idx_nxt   = idx_inc;
          state_nxt = S_FIND_ISSUE;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          out_load       = 1'b1;
          out_data_nxt   = '0;
          out_found_nxt  = pend_found_r;
          out_level_nxt  = LEVEL_W'(level_r);
          out_status_nxt = pend_status_r;
          out_ovr_nxt    = ovr_r;
          out_last_nxt   = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    out_valid_nxt = out_load ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      wr_idx_r    <= '0;
      rd_idx_r    <= '0;
      wrap_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      wr_idx_r    <= wr_idx_nxt;
      rd_idx_r    <= rd_idx_nxt;
      wrap_r      <= wrap_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    level_r       <= level_nxt;
    ovr_r         <= ovr_nxt;
    peek_r        <= peek_nxt;
    cnt_r         <= cnt_nxt;
    n_r           <= n_nxt;
    idx_r         <= idx_nxt;
    pos_r         <= pos_nxt;
    emit_after_r  <= emit_after_nxt;
    match_a_r     <= match_a_nxt;
    match_b_r     <= match_b_nxt;
    match_two_r   <= match_two_nxt;
    pend_status_r <= pend_status_nxt;
    pend_found_r  <= pend_found_nxt;
    out_data_r    <= out_data_nxt;
    out_found_r   <= out_found_nxt;
    out_level_r   <= out_level_nxt;
    out_status_r  <= out_status_nxt;
    out_ovr_r     <= out_ovr_nxt;
    out_last_r    <= out_last_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_data_byte    = out_data_r;
  assign out_found_index  = out_found_r;
  assign out_fill_level   = out_level_r;
  assign out_status       = out_status_r;
  assign out_overrun_seen = out_ovr_r;
  assign out_last         = out_last_r;

  `RXRB_ASSERT_NEXT(a_ovr_resync, in_xfer && op_known && rec_ovr,
    (rd_idx_r == $past(wr_idx_r)) && (wrap_r == WRAP_W'(1)), "overrun did not resync read index")
  `RXRB_ASSERT_NEXT(a_recv_no_result, in_xfer && (in_op == OP_RECV) && !out_valid_r,
    !out_valid_r, "receive transfer produced a result")
  `RXRB_ASSERT_NOW(a_find_in_range, state_r == S_FIND_CMP,
    idx_r < level_r, "find offset beyond fill level")

endmodule
`default_nettype wire

/* bench/tb_top.sv */
`timescale 1ns / 100ps
// Self-checking testbench for the receive ring buffer: directed table, then random traffic
module tb_top;
  import rxrb_pkg::*;

  localparam int unsigned CLK_PERIOD   = 12;
  localparam int unsigned DEPTH        = BUFFER_DEPTH_DEF;
  localparam int unsigned IDLE_PCT     = 21;
  localparam int unsigned RAND_ITEMS   = 145;
  localparam int unsigned MAX_SHOWN    = 10;
  localparam int unsigned TAIL_CYCLES  = 40;
  localparam int unsigned LIMIT_CYCLES = 600000;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [BYTE_W-1:0] rx_byte;
    logic [CNT_W-1:0]  count;
    logic [SKIP_W-1:0] skip;
    logic [BYTE_W-1:0] match_a;
    logic [BYTE_W-1:0] match_b;
    logic              match_two;
  } rx_item_t;

  typedef struct packed {
    logic [BYTE_W-1:0]  data;
    logic [FOUND_W-1:0] found;
    logic [LEVEL_W-1:0] level;
    status_t            status;
    logic               overrun;
    logic               last;
  } rx_result_t;

  typedef struct packed {
    rx_item_t   item;
    logic       typed;
    rx_result_t want;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [OP_W-1:0] in_operation = '0;
  logic [BYTE_W-1:0] in_rx_byte = '0;
  logic [CNT_W-1:0] in_read_count = '0;
  logic [SKIP_W-1:0] in_skip_length = '0;
  logic [BYTE_W-1:0] in_match_a = '0;
  logic [BYTE_W-1:0] in_match_b = '0;
  logic in_match_two = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [BYTE_W-1:0] out_data_byte;
  logic [FOUND_W-1:0] out_found_index;
  logic [LEVEL_W-1:0] out_fill_level;
  logic [STATUS_W-1:0] out_status;
  logic out_overrun_seen;
  logic out_last;

  logic [BYTE_W-1:0] ring_mem [DEPTH];
  bit ring_written [DEPTH];
  logic [7:0] wr_idx = '0;
  logic [7:0] rd_idx = '0;
  logic [WRAP_W-1:0] wraps = '0;
  rx_result_t expected_q [$];
  int unsigned n_mismatch = 0;
  bit calm = 1'b0;

  rx_ring_buffer_with_overrun u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_operation     (in_operation),
    .in_rx_byte       (in_rx_byte),
    .in_read_count    (in_read_count),
    .in_skip_length   (in_skip_length),
    .in_match_a       (in_match_a),
    .in_match_b       (in_match_b),
    .in_match_two     (in_match_two),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_data_byte    (out_data_byte),
    .out_found_index  (out_found_index),
    .out_fill_level   (out_fill_level),
    .out_status       (out_status),
    .out_overrun_seen (out_overrun_seen),
    .out_last         (out_last)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  function automatic logic [LEVEL_W-1:0] recover_level(input logic [7:0] w,
                                                       inout logic [7:0] r,
                                                       inout logic [WRAP_W-1:0] wc,
                                                       output logic ovr);
    ovr = 1'b0;
    if (wc == 2'd0) begin
      return (w >= r) ? LEVEL_W'(w) - LEVEL_W'(r) : '0;
    end
    if (wc == 2'd1 && w <= r) begin
      return LEVEL_W'(DEPTH) - LEVEL_W'(r - w);
    end
    r = w;
    wc = 2'd1;
    ovr = 1'b1;
    return LEVEL_W'(DEPTH);
  endfunction

  function automatic logic [LEVEL_W-1:0] level_preview(output logic [7:0] r);
    logic [WRAP_W-1:0] wc;
    logic ovr;
    r = rd_idx;
    wc = wraps;
    return recover_level(wr_idx, r, wc, ovr);
  endfunction

  function automatic void advance_read(int unsigned n);
    int unsigned pos;
    pos = rd_idx + n;
    while (pos >= DEPTH) begin
      pos -= DEPTH;
      if (wraps != 0) wraps--;
    end
    rd_idx = 8'(pos);
  endfunction

  function automatic void push_result(logic [7:0] data, logic [7:0] found,
                                      logic [LEVEL_W-1:0] level, status_t st,
                                      logic ovr, logic last);
    expected_q.push_back('{data, found, level, st, ovr, last});
  endfunction

  function automatic bit byte_matches(rx_item_t it, logic [7:0] v);
    return v == it.match_a || (it.match_two && v == it.match_b);
  endfunction

  function automatic void predict_item(rx_item_t it);
    logic [LEVEL_W-1:0] level;
    logic ovr;
    int unsigned n;
    logic [7:0] pos;
    bit hit;
    if (it.op == OP_RECV) begin
      ring_mem[wr_idx] = it.rx_byte;
      ring_written[wr_idx] = 1'b1;
      if (wr_idx == 8'(DEPTH - 1) && wraps != WRAP_LIMIT) wraps++;
      wr_idx++;
      return;
    end
    if (it.op > OP_FIND) return;
    level = recover_level(wr_idx, rd_idx, wraps, ovr);
    case (op_t'(it.op))
      OP_READ: begin
        n = it.count;
        if (n == 0) begin
          push_result('0, '0, level, ST_OK, ovr, 1'b1);
        end else if (n > MAX_READ_RUN || level < n) begin
          push_result('0, '0, level, ST_SHORT, ovr, 1'b1);
        end else begin
          for (int unsigned i = 0; i < n; i++) begin
            push_result(ring_mem[8'(rd_idx + i)], '0, level, ST_OK, ovr, i == n - 1);
          end
          advance_read(n);
        end
      end
      OP_PEEK: begin
        if (level != 0) push_result(ring_mem[rd_idx], '0, level, ST_OK, ovr, 1'b1);
        else push_result('0, '0, level, ST_SHORT, ovr, 1'b1);
      end
      OP_SKIP: begin
        advance_read(it.skip);
        push_result('0, '0, level, ST_OK, ovr, 1'b1);
      end
      OP_FIND: begin
        hit = 1'b0;
        for (int unsigned i = 0; i < level && !hit; i++) begin
          pos = 8'(rd_idx + i);
          if (byte_matches(it, ring_mem[pos])) begin
            push_result('0, 8'(i), level, ST_OK, ovr, 1'b1);
            hit = 1'b1;
          end
        end
        if (!hit) push_result('0, '0, level, ST_NOT_FOUND, ovr, 1'b1);
      end
      default: ;
    endcase
  endfunction

  function automatic bit reads_unwritten(rx_item_t it);
    logic [7:0] r;
    logic [LEVEL_W-1:0] level;
    logic [7:0] pos;
    if (it.op == OP_RECV || it.op > OP_FIND) return 1'b0;
    level = level_preview(r);
    case (op_t'(it.op))
      OP_READ: begin
        if (it.count == 0 || it.count > MAX_READ_RUN || level < it.count) return 1'b0;
        for (int unsigned i = 0; i < it.count; i++) begin
          if (!ring_written[8'(r + i)]) return 1'b1;
        end
        return 1'b0;
      end
      OP_PEEK: return level != 0 && !ring_written[r];
      OP_FIND: begin
        for (int unsigned i = 0; i < level; i++) begin
          pos = 8'(r + i);
          if (!ring_written[pos]) return 1'b1;
          if (byte_matches(it, ring_mem[pos])) return 1'b0;
        end
        return 1'b0;
      end
      default: return 1'b0;
    endcase
  endfunction

  function automatic rx_item_t mk_item(logic [OP_W-1:0] op, logic [7:0] b, logic [6:0] cnt,
                                       logic [8:0] skip, logic [7:0] ma, logic [7:0] mb,
                                       logic two);
    return '{op, b, cnt, skip, ma, mb, two};
  endfunction

  function automatic rx_result_t mk_res(logic [7:0] data, logic [7:0] found,
                                        logic [LEVEL_W-1:0] level, status_t st);
    return '{data, found, level, st, 1'b0, 1'b1};
  endfunction

  function automatic rx_item_t random_item(logic [OP_W-1:0] op);
    rx_item_t it;
    it.op = op;
    it.rx_byte = 8'($urandom_range(0, 255));
    it.count = 7'($urandom_range(0, 127));
    it.skip = 9'($urandom_range(0, DEPTH));
    it.match_a = 8'($urandom_range(0, 255));
    it.match_b = 8'($urandom_range(0, 255));
    it.match_two = 1'($urandom_range(0, 1));
    return it;
  endfunction

  task automatic send_item(rx_item_t it);
    while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
      @(negedge clk);
      in_valid <= 1'b0;
      @(posedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_operation <= it.op;
    in_rx_byte <= it.rx_byte;
    in_read_count <= it.count;
    in_skip_length <= it.skip;
    in_match_a <= it.match_a;
    in_match_b <= it.match_b;
    in_match_two <= it.match_two;
    do @(posedge clk); while (!in_ready);
    predict_item(it);
  endtask

  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
  endtask

  always @(negedge clk) out_ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);

  always @(posedge clk) begin
    rx_result_t got;
    rx_result_t want;
    if (rst_n && out_valid && out_ready) begin
      got = '{out_data_byte, out_found_index, out_fill_level, status_t'(out_status),
              out_overrun_seen, out_last};
      if (expected_q.size() == 0) begin
        if (n_mismatch < MAX_SHOWN)
          $display("unexpected transfer: data %02h found %0d level %0d status %0d ovr %b last %b",
                   got.data, got.found, got.level, got.status, got.overrun, got.last);
        n_mismatch++;
      end else begin
        want = expected_q.pop_front();
        if (got !== want) begin
          if (n_mismatch < MAX_SHOWN)
            $display({"mismatch: exp data %02h found %0d level %0d status %0d ovr %b last %b",
                      " / got data %02h found %0d level %0d status %0d ovr %b last %b"},
                     want.data, want.found, want.level, want.status, want.overrun, want.last,
                     got.data, got.found, got.level, got.status, got.overrun, got.last);
          n_mismatch++;
        end
      end
    end
  end

  initial begin
    dir_row_t dir_rows [$];
    rx_item_t it;
    logic [7:0] r;
    logic [LEVEL_W-1:0] lvl;
    logic [7:0] pick;
    int unsigned done;
    int unsigned len;
    int unsigned sel;
    bit drained;

    dir_rows.push_back('{mk_item(OP_PEEK, 8'h00, 7'd0, 9'd0, 8'h00, 8'h00, 1'b0), 1'b1,
                         mk_res(8'h00, 8'd0, 9'd0, ST_SHORT)});
    dir_rows.push_back('{mk_item(OP_READ, 8'h00, 7'd1, 9'd0, 8'h00, 8'h00, 1'b0), 1'b1,
                         mk_res(8'h00, 8'd0, 9'd0, ST_SHORT)});
    dir_rows.push_back('{mk_item(OP_READ, 8'h00, 7'd0, 9'd0, 8'h00, 8'h00, 1'b0), 1'b1,
                         mk_res(8'h00, 8'd0, 9'd0, ST_OK)});
    dir_rows.push_back('{mk_item(OP_FIND, 8'h00, 7'd0, 9'd0, 8'hFF, 8'h00, 1'b1), 1'b1,
                         mk_res(8'h00, 8'd0, 9'd0, ST_NOT_FOUND)});
    dir_rows.push_back('{mk_item(OP_FIND + 3'd1, 8'hFF, 7'h7F, 9'h1FF, 8'hFF, 8'hFF, 1'b1),
                         1'b0, '0});
    dir_rows.push_back('{mk_item(OP_FIND + 3'd2, 8'h00, 7'd0, 9'd0, 8'h00, 8'h00, 1'b0),
                         1'b0, '0});
    dir_rows.push_back('{mk_item(OP_FIND + 3'd3, 8'hFF, 7'h7F, 9'h1FF, 8'hFF, 8'hFF, 1'b1),
                         1'b0, '0});
    dir_rows.push_back('{mk_item(OP_RECV, 8'h00, 7'd0, 9'd0, 8'h00, 8'h00, 1'b0), 1'b0, '0});
    dir_rows.push_back('{mk_item(OP_RECV, 8'hFF, 7'd0, 9'd0, 8'h00, 8'h00, 1'b0), 1'b0, '0});
    dir_rows.push_back('{mk_item(OP_RECV, 8'hA5, 7'd0, 9'd0, 8'h00, 8'h00, 1'b0), 1'b0, '0});
    dir_rows.push_back('{mk_item(OP_RECV, 8'h5A, 7'd0, 9'd0, 8'h00, 8'h00, 1'b0), 1'b0, '0});
    dir_rows.push_back('{mk_item(OP_RECV, 8'h3C, 7'd0, 9'd0, 8'h00, 8'h00, 1'b0), 1'b0, '0});
    dir_rows.push_back('{mk_item(OP_PEEK, 8'h00, 7'd0, 9'd0, 8'h00, 8'h00, 1'b0), 1'b1,
                         mk_res(8'h00, 8'd0, 9'd5, ST_OK)});
    dir_rows.push_back('{mk_item(OP_FIND, 8'h00, 7'd0, 9'd0, 8'hA5, 8'h00, 1'b0), 1'b1,
                         mk_res(8'h00, 8'd2, 9'd5, ST_OK)});
    dir_rows.push_back('{mk_item(OP_FIND, 8'h00, 7'd0, 9'd0, 8'h11, 8'h5A, 1'b1), 1'b1,
                         mk_res(8'h00, 8'd3, 9'd5, ST_OK)});
    dir_rows.push_back('{mk_item(OP_FIND, 8'h00, 7'd0, 9'd0, 8'h11, 8'h5A, 1'b0), 1'b1,
                         mk_res(8'h00, 8'd0, 9'd5, ST_NOT_FOUND)});
    dir_rows.push_back('{mk_item(OP_READ, 8'h00, 7'h7F, 9'd0, 8'h00, 8'h00, 1'b0), 1'b1,
                         mk_res(8'h00, 8'd0, 9'd5, ST_SHORT)});
    dir_rows.push_back('{mk_item(OP_READ, 8'h00, 7'd6, 9'd0, 8'h00, 8'h00, 1'b0), 1'b1,
                         mk_res(8'h00, 8'd0, 9'd5, ST_SHORT)});
    dir_rows.push_back('{mk_item(OP_READ, 8'h00, 7'd2, 9'd0, 8'h00, 8'h00, 1'b0), 1'b0, '0});
    dir_rows.push_back('{mk_item(OP_SKIP, 8'h00, 7'd0, 9'd0, 8'h00, 8'h00, 1'b0), 1'b1,
                         mk_res(8'h00, 8'd0, 9'd3, ST_OK)});
    dir_rows.push_back('{mk_item(OP_READ, 8'h00, 7'd3, 9'd0, 8'h00, 8'h00, 1'b0), 1'b0, '0});
    dir_rows.push_back('{mk_item(OP_SKIP, 8'h00, 7'd0, 9'd7, 8'h00, 8'h00, 1'b0), 1'b1,
                         mk_res(8'h00, 8'd0, 9'd0, ST_OK)});
    dir_rows.push_back('{mk_item(OP_PEEK, 8'h00, 7'd0, 9'd0, 8'h00, 8'h00, 1'b0), 1'b1,
                         mk_res(8'h00, 8'd0, 9'd0, ST_SHORT)});
    dir_rows.push_back('{mk_item(OP_SKIP, 8'h00, 7'd0, 9'd256, 8'h00, 8'h00, 1'b0), 1'b1,
                         mk_res(8'h00, 8'd0, 9'd0, ST_OK)});
    dir_rows.push_back('{mk_item(OP_SKIP, 8'h00, 7'd0, 9'd255, 8'h00, 8'h00, 1'b0), 1'b1,
                         mk_res(8'h00, 8'd0, 9'd0, ST_OK)});

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i]) begin
      send_item(dir_rows[i].item);
      if (dir_rows[i].typed) expected_q[expected_q.size() - 1] = dir_rows[i].want;
    end
    drain_results();

    done = 0;
    drained = 1'b0;
    while (done < RAND_ITEMS) begin
      calm = (done >= 60 && done < 100);
      if (!drained && done >= 120) begin
        drain_results();
        drained = 1'b1;
      end
      sel = $urandom_range(0, 99);
      if (sel < 40) begin
        len = $urandom_range(1, 24);
        repeat (len) begin
          send_item(random_item(OP_RECV));
          done++;
        end
      end else if (sel < 43) begin
        send_item(random_item(3'($urandom_range(int'(OP_FIND) + 1, (1 << OP_W) - 1))));
        done++;
      end else begin
        lvl = level_preview(r);
        sel = $urandom_range(0, 99);
        if (sel < 35) begin
          it = random_item(OP_READ);
          if (lvl != 0 && $urandom_range(0, 3) != 0)
            it.count = 7'($urandom_range(1, (lvl < MAX_READ_RUN) ? lvl : MAX_READ_RUN));
        end else if (sel < 50) begin
          it = random_item(OP_PEEK);
        end else if (sel < 70) begin
          it = random_item(OP_SKIP);
          if ($urandom_range(0, 1) != 0) it.skip = 9'($urandom_range(0, lvl));
        end else begin
          it = random_item(OP_FIND);
          if (lvl != 0 && $urandom_range(0, 1) != 0) begin
            pick = 8'(r + $urandom_range(0, lvl - 1));
            if (ring_written[pick]) it.match_a = ring_mem[pick];
          end
        end
        if (reads_unwritten(it)) it.op = OP_RECV;
        send_item(it);
        done++;
      end
    end
    calm = 1'b0;

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (n_mismatch == 0 && expected_q.size() == 0) begin
      $display("[rx_ring_buffer_with_overrun] OK");
    end else begin
      $display("[rx_ring_buffer_with_overrun] ERROR");
    end
    $finish;
  end

  initial begin
    #(CLK_PERIOD * LIMIT_CYCLES);
    $display("[rx_ring_buffer_with_overrun] ERROR");
    $finish;
  end

endmodule
